/* hw/rtl/vfa_pkg.sv */
// Shared types and constants for the four-component fixed-point vector ALU.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package vfa_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int EPS_W         = 17;

	// Stage counts of the three pipeline sections
	localparam int FRONT_STAGES = 5;
	localparam int SQRT_STAGES  = 32;
	localparam int DIV_STEPS    = 32;
	localparam int DIV_STAGES   = DIV_STEPS + 1;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_NEG     = 4'd2,
		OP_SCALE   = 4'd3,
		OP_DIV     = 4'd4,
		OP_DOT     = 4'd5,
		OP_CROSS   = 4'd6,
		OP_MAG     = 4'd7,
		OP_NORM    = 4'd8,
		OP_REFLECT = 4'd9,
		OP_EQUAL   = 4'd10,
		OP_ISPOINT = 4'd11
	} op_t;

	// Word state that rides alongside the square root and divider pipes
	typedef struct packed {
		logic [3:0]       kind;
		logic [3:0][31:0] a;
		logic [31:0]      s;
		logic [3:0][31:0] r;
		logic [31:0]      sc;
		logic             flag;
	} side_t;

	// Per-lane divider result
	typedef struct packed {
		logic [31:0] q;
		logic        ovf;
		logic        neg;
	} lane_t;

endpackage

/* hw/rtl/vfa_front.sv */
// Front pipeline: input capture, products, sums and reflect (five stages).
// Depends on vfa_pkg for op codes and the side_t word record.
`timescale 1ns / 1ps

module vfa_front import vfa_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [3:0]           kind,
	input  logic [3:0][31:0]     a,
	input  logic [3:0][31:0]     b,
	input  logic [31:0]          s,
	input  logic [EPS_W-1:0]     eps,
	output logic                 out_valid,
	output side_t                out_side,
	output logic [63:0]          out_sumsq
);

	localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	function automatic logic [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) return 32'h7FFF_FFFF;
		else if (v < -68'sd2147483648) return 32'h8000_0000;
		else return v[31:0];
	endfunction

	// Stage 1: capture the word
	logic               v_s1;
	logic [3:0]         kind_s1;
	logic signed [31:0] a_s1 [4];
	logic signed [31:0] b_s1 [4];
	logic signed [31:0] s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		s_s1    <= s;
		for (int i = 0; i < 4; i++) begin
			a_s1[i] <= a[i];
			b_s1[i] <= b[i];
		end
	end

	// Stage 2: pick multiplier operands by op
	op_t                op1;
	logic signed [31:0] mx [6];
	logic signed [31:0] my [6];

	always_comb begin
		op1 = op_t'(kind_s1);
		for (int i = 0; i < 4; i++) begin
			mx[i] = a_s1[i];
			my[i] = b_s1[i];
		end
		mx[4] = a_s1[0];
		my[4] = b_s1[1];
		mx[5] = a_s1[1];
		my[5] = b_s1[0];
		case (op1)
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) my[i] = s_s1;
			end
			OP_MAG, OP_NORM: begin
				for (int i = 0; i < 4; i++) my[i] = a_s1[i];
			end
			OP_CROSS: begin
				mx[0] = a_s1[1]; my[0] = b_s1[2];
				mx[1] = a_s1[2]; my[1] = b_s1[1];
				mx[2] = a_s1[2]; my[2] = b_s1[0];
				mx[3] = a_s1[0]; my[3] = b_s1[2];
			end
			default: ;
		endcase
	end

	// Stage 2: add, subtract, negate and the two flag tests
	logic [31:0]        smp [4];
	logic signed [32:0] sum1;
	logic signed [32:0] dif1;
	logic [32:0]        mag1;
	logic               eq1;
	logic               flag1;

	always_comb begin
		eq1  = 1'b1;
		sum1 = '0;
		dif1 = '0;
		mag1 = '0;
		for (int i = 0; i < 4; i++) begin
			sum1 = 33'(a_s1[i]) + 33'(b_s1[i]);
			dif1 = 33'(a_s1[i]) - 33'(b_s1[i]);
			mag1 = dif1[32] ? (33'd0 - 33'(dif1)) : 33'(dif1);
			if (!(mag1 < 33'(eps))) eq1 = 1'b0;
			case (op1)
				OP_ADD:  smp[i] = sat32(68'(sum1));
				OP_SUB:  smp[i] = sat32(68'(dif1));
				OP_NEG:  smp[i] = sat32(68'(33'sd0 - 33'(a_s1[i])));
				default: smp[i] = 32'd0;
			endcase
		end
		case (op1)
			OP_EQUAL:   flag1 = eq1;
			OP_ISPOINT: flag1 = (a_s1[3] == ONE);
			default:    flag1 = 1'b0;
		endcase
	end

	logic               v_s2;
	op_t                op_s2;
	logic signed [31:0] a_s2 [4];
	logic signed [31:0] b_s2 [4];
	logic signed [31:0] s_s2;
	logic signed [63:0] p_s2 [6];
	logic [31:0]        smp_s2 [4];
	logic               flag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		op_s2   <= op1;
		s_s2    <= s_s1;
		flag_s2 <= flag1;
		for (int i = 0; i < 4; i++) begin
			a_s2[i]   <= a_s1[i];
			b_s2[i]   <= b_s1[i];
			smp_s2[i] <= smp[i];
		end
		for (int i = 0; i < 6; i++) p_s2[i] <= mx[i] * my[i];
	end

	// Stage 3: sum products, shift back to fixed point, saturate
	logic signed [65:0] dsum;
	logic signed [64:0] cr [3];
	logic [64:0]        sq;
	logic [31:0]        r2 [4];
	logic [31:0]        d2;

	always_comb begin
		dsum = 66'(p_s2[0]) + 66'(p_s2[1]) + 66'(p_s2[2]) + 66'(p_s2[3]);
		d2   = sat32(68'(dsum >>> FRAC_BITS));
		cr[0] = 65'(p_s2[0]) - 65'(p_s2[1]);
		cr[1] = 65'(p_s2[2]) - 65'(p_s2[3]);
		cr[2] = 65'(p_s2[4]) - 65'(p_s2[5]);
		sq = {1'b0, p_s2[0]} + {1'b0, p_s2[1]} + {1'b0, p_s2[2]} + {1'b0, p_s2[3]};
		case (op_s2)
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) r2[i] = sat32(68'(p_s2[i] >>> FRAC_BITS));
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) r2[i] = sat32(68'(cr[i] >>> FRAC_BITS));
				r2[3] = 32'd0;
			end
			OP_ADD, OP_SUB, OP_NEG: begin
				for (int i = 0; i < 4; i++) r2[i] = smp_s2[i];
			end
			default: begin
				for (int i = 0; i < 4; i++) r2[i] = 32'd0;
			end
		endcase
	end

	logic               v_s3;
	op_t                op_s3;
	logic signed [31:0] a_s3 [4];
	logic signed [31:0] b_s3 [4];
	logic [31:0]        s_s3;
	logic [31:0]        r_s3 [4];
	logic signed [31:0] d_s3;
	logic [31:0]        sc_s3;
	logic               flag_s3;
	logic [63:0]        sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		s_s3    <= s_s2;
		d_s3    <= d2;
		sc_s3   <= (op_s2 == OP_DOT) ? d2 : 32'd0;
		flag_s3 <= flag_s2;
		sq_s3   <= sq[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq[63:0];
		for (int i = 0; i < 4; i++) begin
			a_s3[i] <= a_s2[i];
			b_s3[i] <= b_s2[i];
			r_s3[i] <= r2[i];
		end
	end

	// Stage 4: scale the normal by the saturated dot product
	logic               v_s4;
	op_t                op_s4;
	logic signed [31:0] a_s4 [4];
	logic [31:0]        s_s4;
	logic [31:0]        r_s4 [4];
	logic signed [63:0] q_s4 [4];
	logic [31:0]        sc_s4;
	logic               flag_s4;
	logic [63:0]        sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		op_s4   <= op_s3;
		s_s4    <= s_s3;
		sc_s4   <= sc_s3;
		flag_s4 <= flag_s3;
		sq_s4   <= sq_s3;
		for (int i = 0; i < 4; i++) begin
			a_s4[i] <= a_s3[i];
			r_s4[i] <= r_s3[i];
			q_s4[i] <= b_s3[i] * d_s3;
		end
	end

	// Stage 5: finish reflect and pack the word record
	logic signed [65:0] t4;
	logic signed [65:0] rr4;
	side_t              side4;

	always_comb begin
		t4  = '0;
		rr4 = '0;
		side4.kind = op_s4;
		side4.s    = s_s4;
		side4.sc   = sc_s4;
		side4.flag = flag_s4;
		for (int i = 0; i < 4; i++) begin
			t4  = 66'(q_s4[i]) >>> FRAC_BITS;
			rr4 = 66'(a_s4[i]) - (t4 <<< 1);
			side4.a[i] = a_s4[i];
			side4.r[i] = (op_s4 == OP_REFLECT) ? sat32(68'(rr4)) : r_s4[i];
		end
	end

	logic        v_s5;
	side_t       side_s5;
	logic [63:0] sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		side_s5 <= side4;
		sq_s5   <= sq_s4;
	end

	assign out_valid = v_s5;
	assign out_side  = side_s5;
	assign out_sumsq = sq_s5;

endmodule

/* hw/rtl/vfa_sqrt.sv */
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on vfa_pkg for side_t and the stage count.
`timescale 1ns / 1ps

module vfa_sqrt import vfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  side_t       in_side,
	input  logic [63:0] in_n,
	output logic        out_valid,
	output side_t       out_side,
	output logic [31:0] out_root
);

	logic        v_s    [1:SQRT_STAGES];
	side_t       side_s [1:SQRT_STAGES];
	logic [63:0] n_s    [1:SQRT_STAGES];
	logic [33:0] rem_s  [1:SQRT_STAGES];
	logic [31:0] root_s [1:SQRT_STAGES];

	for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_step
		logic        v_p;
		side_t       side_p;
		logic [63:0] n_p;
		logic [33:0] rem_p;
		logic [31:0] root_p;
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		if (k == 1) begin : g_first
			assign v_p    = in_valid;
			assign side_p = in_side;
			assign n_p    = in_n;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign side_p = side_s[k-1];
			assign n_p    = n_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		// Bring down two bits, try root*4+1
		assign cur   = {rem_p, n_p[63:62]};
		assign trial = {2'b00, root_p, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_p;
			n_s[k]    <= {n_p[61:0], 2'b00};
			rem_s[k]  <= ge ? 34'(cur - trial) : cur[33:0];
			root_s[k] <= {root_p[30:0], ge};
		end
	end

	assign out_valid = v_s[SQRT_STAGES];
	assign out_side  = side_s[SQRT_STAGES];
	assign out_root  = root_s[SQRT_STAGES];

endmodule

/* hw/rtl/vfa_div.sv */
// Four-lane pipelined restoring divider: (|a| << FRAC_BITS) / divisor.
// Setup stage plus one quotient bit per stage; depends on vfa_pkg.
`timescale 1ns / 1ps

module vfa_div import vfa_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  side_t       in_side,
	input  logic [31:0] in_mag,
	output logic        out_valid,
	output side_t       out_side,
	output logic [31:0] out_mag,
	output lane_t [3:0] out_lane
);

	// Setup: pick divisor, take magnitudes, test for quotient overflow
	op_t         op0;
	logic        is_div;
	logic [31:0] s_abs;
	logic [31:0] dvs0;
	logic [31:0] a_abs [4];
	logic [63:0] num [4];

	always_comb begin
		op0    = op_t'(in_side.kind);
		is_div = (op0 == OP_DIV);
		s_abs  = in_side.s[31] ? (32'd0 - in_side.s) : in_side.s;
		dvs0   = is_div ? s_abs : in_mag;
		for (int i = 0; i < 4; i++) begin
			a_abs[i] = in_side.a[i][31] ? (32'd0 - in_side.a[i]) : in_side.a[i];
			num[i]   = 64'(a_abs[i]) << FRAC_BITS;
		end
	end

	logic        v_s0;
	side_t       side_s0;
	logic [31:0] mag_s0;
	logic [31:0] dvs_s0;
	logic [31:0] rem_s0 [4];
	logic [31:0] lo_s0 [4];
	logic        ovf_s0 [4];
	logic        neg_s0 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s0 <= 1'b0;
		else v_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		side_s0 <= in_side;
		mag_s0  <= in_mag;
		dvs_s0  <= dvs0;
		for (int i = 0; i < 4; i++) begin
			rem_s0[i] <= num[i][63:32];
			lo_s0[i]  <= num[i][31:0];
			ovf_s0[i] <= (num[i][63:32] >= dvs0);
			neg_s0[i] <= in_side.a[i][31] ^ (is_div & in_side.s[31]);
		end
	end

	logic        v_s    [1:DIV_STEPS];
	side_t       side_s [1:DIV_STEPS];
	logic [31:0] mag_s  [1:DIV_STEPS];
	logic [31:0] dvs_s  [1:DIV_STEPS];
	logic [31:0] rem_s  [1:DIV_STEPS][4];
	logic [31:0] lo_s   [1:DIV_STEPS][4];
	logic [31:0] q_s    [1:DIV_STEPS][4];
	logic        ovf_s  [1:DIV_STEPS][4];
	logic        neg_s  [1:DIV_STEPS][4];

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic        v_p;
		side_t       side_p;
		logic [31:0] mag_p;
		logic [31:0] dvs_p;
		logic [31:0] rem_p [4];
		logic [31:0] lo_p [4];
		logic [31:0] q_p [4];
		logic        ovf_p [4];
		logic        neg_p [4];
		logic [32:0] cur [4];
		logic        ge [4];

		if (k == 1) begin : g_first
			always_comb begin
				v_p    = v_s0;
				side_p = side_s0;
				mag_p  = mag_s0;
				dvs_p  = dvs_s0;
				for (int i = 0; i < 4; i++) begin
					rem_p[i] = rem_s0[i];
					lo_p[i]  = lo_s0[i];
					q_p[i]   = 32'd0;
					ovf_p[i] = ovf_s0[i];
					neg_p[i] = neg_s0[i];
				end
			end
		end else begin : g_next
			always_comb begin
				v_p    = v_s[k-1];
				side_p = side_s[k-1];
				mag_p  = mag_s[k-1];
				dvs_p  = dvs_s[k-1];
				for (int i = 0; i < 4; i++) begin
					rem_p[i] = rem_s[k-1][i];
					lo_p[i]  = lo_s[k-1][i];
					q_p[i]   = q_s[k-1][i];
					ovf_p[i] = ovf_s[k-1][i];
					neg_p[i] = neg_s[k-1][i];
				end
			end
		end

		// Shift in the next dividend bit, subtract when it fits
		always_comb begin
			for (int i = 0; i < 4; i++) begin
				cur[i] = {rem_p[i], lo_p[i][31]};
				ge[i]  = (cur[i] >= {1'b0, dvs_p});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_p;
			mag_s[k]  <= mag_p;
			dvs_s[k]  <= dvs_p;
			for (int i = 0; i < 4; i++) begin
				rem_s[k][i] <= ge[i] ? 32'(cur[i] - {1'b0, dvs_p}) : cur[i][31:0];
				lo_s[k][i]  <= {lo_p[i][30:0], 1'b0};
				q_s[k][i]   <= {q_p[i][30:0], ge[i]};
				ovf_s[k][i] <= ovf_p[i];
				neg_s[k][i] <= neg_p[i];
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];
	assign out_mag   = mag_s[DIV_STEPS];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			out_lane[i].q   = q_s[DIV_STEPS][i];
			out_lane[i].ovf = ovf_s[DIV_STEPS][i];
			out_lane[i].neg = neg_s[DIV_STEPS][i];
		end
	end

endmodule

/* hw/rtl/vec4_fixed_point_alu.sv */
// Top level of the four-component fixed-point vector ALU.
// Instantiates vfa_front, vfa_sqrt and vfa_div; depends on vfa_pkg.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------------------
//   command  | start / busy      | kind, a_x..a_w, b_x..b_w, scalar_in
//   result   | done (strobe)     | r_x..r_w, scalar_out, flag, error
//   config   | cfg_we            | cfg_wdata (epsilon)
//
// One word is taken every cycle; busy stays low. Every word reaches the result
// ports through the same registers (5 front stages, 32 square
// root stages, a divider setup stage and 32 divider stages, one output register),
// for every opcode alike, so results leave in order. The depth comes from the
// bit-per-stage square root and divider. Reset clears all valid bits and sets
// epsilon to 1; results show for exactly one cycle with done high.
`timescale 1ns / 1ps

module vec4_fixed_point_alu import vfa_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         kind,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] scalar_in,
	input  logic               cfg_we,
	input  logic [EPS_W-1:0]   cfg_wdata,
	output logic               done,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] r_w,
	output logic signed [31:0] scalar_out,
	output logic               flag,
	output logic               error
);

	localparam int LATENCY = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

	function automatic logic [31:0] lane_sat(input lane_t l);
		if (!l.neg) return (l.ovf || l.q[31]) ? 32'h7FFF_FFFF : l.q;
		else return (l.ovf || l.q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - l.q);
	endfunction

	// Epsilon register
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eps_q <= EPS_W'(1);
		else if (cfg_we) eps_q <= cfg_wdata;
	end

	assign busy = 1'b0;

	// Front section
	logic        fr_valid;
	side_t       fr_side;
	logic [63:0] fr_sumsq;

	vfa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.kind      (kind),
		.a         ({a_w, a_z, a_y, a_x}),
		.b         ({b_w, b_z, b_y, b_x}),
		.s         (scalar_in),
		.eps       (eps_q),
		.out_valid (fr_valid),
		.out_side  (fr_side),
		.out_sumsq (fr_sumsq)
	);

	// Magnitude
	logic        sq_valid;
	side_t       sq_side;
	logic [31:0] sq_root;

	vfa_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_side   (fr_side),
		.in_n      (fr_sumsq),
		.out_valid (sq_valid),
		.out_side  (sq_side),
		.out_root  (sq_root)
	);

	// Divide and normalize
	logic        dv_valid;
	side_t       dv_side;
	logic [31:0] dv_mag;
	lane_t [3:0] dv_lane;

	vfa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_side   (sq_side),
		.in_mag    (sq_root),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_mag   (dv_mag),
		.out_lane  (dv_lane)
	);

	// Merge quotients, magnitude and error into the result word
	op_t         op_o;
	logic        err_o;
	logic [31:0] r_o [4];
	logic [31:0] sc_o;

	always_comb begin
		op_o  = op_t'(dv_side.kind);
		err_o = (op_o == OP_DIV && dv_side.s == 32'd0) ||
			(op_o == OP_NORM && dv_mag == 32'd0);
		sc_o = dv_side.sc;
		if (op_o == OP_MAG) sc_o = dv_mag[31] ? 32'h7FFF_FFFF : dv_mag;
		for (int i = 0; i < 4; i++) begin
			if (op_o == OP_DIV || op_o == OP_NORM)
				r_o[i] = err_o ? 32'd0 : lane_sat(dv_lane[i]);
			else
				r_o[i] = dv_side.r[i];
		end
	end

	// Output register
	logic        done_q;
	logic [31:0] r_q [4];
	logic [31:0] sc_q;
	logic        flag_q;
	logic        err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (dv_valid) begin
			for (int i = 0; i < 4; i++) r_q[i] <= r_o[i];
			sc_q   <= sc_o;
			flag_q <= dv_side.flag;
			err_q  <= err_o;
		end
	end

	assign done       = done_q;
	assign r_x        = r_q[0];
	assign r_y        = r_q[1];
	assign r_z        = r_q[2];
	assign r_w        = r_q[3];
	assign scalar_out = sc_q;
	assign flag       = flag_q;
	assign error      = err_q;

	// Every accepted word comes out after the fixed pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word did not complete on time");

	// No result without a word taken the pipeline depth earlier
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching word");

	// An error word carries an all-zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (r_x == 32'sd0 && r_y == 32'sd0 && r_z == 32'sd0 &&
		r_w == 32'sd0 && scalar_out == 32'sd0 && !flag))
		else $error("error word has nonzero fields");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for vec4_fixed_point_alu: directed and random command words,
// a predictor of the expected result for each accepted word, and a result checker.
// Depends on vfa_pkg and the RTL of vec4_fixed_point_alu.
`timescale 1ns / 1ps

module tb_top;
	import vfa_pkg::*;

	typedef enum logic [1:0] {
		ENT_CMD   = 2'd0,
		ENT_EPS   = 2'd1,
		ENT_DRAIN = 2'd2
	} ent_kind_t;

	typedef struct packed {
		ent_kind_t        ek;
		logic [3:0]       kind;
		logic [3:0][31:0] a;
		logic [3:0][31:0] b;
		logic [31:0]      s;
		logic [EPS_W-1:0] eps;
	} cmd_t;

	typedef struct packed {
		logic [3:0][31:0] r;
		logic [31:0]      sc;
		logic             flag;
		logic             err;
	} vres_t;

	localparam int FB          = DEF_FRAC_BITS;
	localparam int LATENCY     = 71;
	localparam int STALL_LIMIT = 2000;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;
	localparam logic [31:0] MAXV  = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV  = 32'h8000_0000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         kind;
	logic signed [31:0] a_x, a_y, a_z, a_w;
	logic signed [31:0] b_x, b_y, b_z, b_w;
	logic signed [31:0] scalar_in;
	logic               cfg_we;
	logic [EPS_W-1:0]   cfg_wdata;
	logic               done;
	logic signed [31:0] r_x, r_y, r_z, r_w;
	logic signed [31:0] scalar_out;
	logic               flag;
	logic               error;

	cmd_t  pending_q[$];
	vres_t expected_q[$];
	cmd_t  cur_cmd;
	logic [EPS_W-1:0] eps_model;
	int    fail_cnt;
	int    burst_left;
	int    gap_left;
	int    quiet_cycles;

	vec4_fixed_point_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.scalar_in(scalar_in), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
		.scalar_out(scalar_out), .flag(flag), .error(error)
	);

	// Clamp a wide signed value to the 32-bit range
	function automatic logic [31:0] sat_q(logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF)
			return MAXV;
		if (v < -128'sh8000_0000)
			return MINV;
		return v[31:0];
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] root_of_squares(logic signed [127:0] v[4]);
		logic [127:0] acc;
		acc = 0;
		for (int i = 0; i < 4; i++)
			acc = acc + 128'(v[i] * v[i]);
		if (acc > 128'hFFFF_FFFF_FFFF_FFFF)
			acc = 128'hFFFF_FFFF_FFFF_FFFF;
		return isqrt(acc[63:0]);
	endfunction

	// Expected result word of one command under the given tolerance
	function automatic vres_t alu_predict(cmd_t c, logic [EPS_W-1:0] eps);
		vres_t o;
		logic signed [127:0] va[4], vb[4];
		logic signed [127:0] sv, acc, d, diff;
		logic [63:0] m;
		o = '0;
		for (int i = 0; i < 4; i++) begin
			va[i] = 128'(signed'(c.a[i]));
			vb[i] = 128'(signed'(c.b[i]));
		end
		sv = 128'(signed'(c.s));
		acc = 0;
		for (int i = 0; i < 4; i++)
			acc = acc + va[i] * vb[i];
		d = 128'(signed'(sat_q(acc >>> FB)));
		case (c.kind)
			OP_ADD: for (int i = 0; i < 4; i++) o.r[i] = sat_q(va[i] + vb[i]);
			OP_SUB: for (int i = 0; i < 4; i++) o.r[i] = sat_q(va[i] - vb[i]);
			OP_NEG: for (int i = 0; i < 4; i++) o.r[i] = sat_q(-va[i]);
			OP_SCALE: for (int i = 0; i < 4; i++) o.r[i] = sat_q((va[i] * sv) >>> FB);
			OP_DIV: begin
				if (sv == 0)
					o.err = 1'b1;
				else
					for (int i = 0; i < 4; i++) o.r[i] = sat_q((va[i] <<< FB) / sv);
			end
			OP_DOT: o.sc = d[31:0];
			OP_CROSS: begin
				o.r[0] = sat_q((va[1] * vb[2] - va[2] * vb[1]) >>> FB);
				o.r[1] = sat_q((va[2] * vb[0] - va[0] * vb[2]) >>> FB);
				o.r[2] = sat_q((va[0] * vb[1] - va[1] * vb[0]) >>> FB);
			end
			OP_MAG: begin
				m = root_of_squares(va);
				o.sc = (m > 64'h7FFF_FFFF) ? MAXV : m[31:0];
			end
			OP_NORM: begin
				m = root_of_squares(va);
				if (m == 0)
					o.err = 1'b1;
				else
					for (int i = 0; i < 4; i++)
						o.r[i] = sat_q((va[i] <<< FB) / signed'(128'(m)));
			end
			OP_REFLECT: for (int i = 0; i < 4; i++)
				o.r[i] = sat_q(va[i] - 2 * ((vb[i] * d) >>> FB));
			OP_EQUAL: begin
				o.flag = 1'b1;
				for (int i = 0; i < 4; i++) begin
					diff = va[i] - vb[i];
					if (diff < 0)
						diff = -diff;
					if (!(diff < 128'(eps)))
						o.flag = 1'b0;
				end
			end
			OP_ISPOINT: o.flag = (c.a[3] == ONE_Q);
			default: ;
		endcase
		return o;
	endfunction

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: hold a word until taken, idle in gaps, write epsilon only when drained
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= '0;
			{a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in} <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			cur_cmd <= '0;
			eps_model <= EPS_W'(1);
			burst_left <= 1;
			gap_left <= 0;
			quiet_cycles <= 0;
		end else begin
			cfg_we <= 1'b0;
			quiet_cycles <= (expected_q.size() == 0) ? quiet_cycles + 1 : 0;
			if (start && !busy)
				expected_q.push_back(alu_predict(cur_cmd, eps_model));
			if (start && busy) begin
				// hold the word
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_q.size() == 0) begin
				start <= 1'b0;
			end else if (pending_q[0].ek != ENT_CMD) begin
				start <= 1'b0;
				if (!(start && !busy) && expected_q.size() == 0 && quiet_cycles > 2) begin
					if (pending_q[0].ek == ENT_EPS) begin
						cfg_we <= 1'b1;
						cfg_wdata <= pending_q[0].eps;
						eps_model <= pending_q[0].eps;
					end
					void'(pending_q.pop_front());
				end
			end else begin
				start <= 1'b1;
				kind <= pending_q[0].kind;
				{a_w, a_z, a_y, a_x} <= pending_q[0].a;
				{b_w, b_z, b_y, b_x} <= pending_q[0].b;
				scalar_in <= pending_q[0].s;
				cur_cmd <= pending_q[0];
				void'(pending_q.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		vres_t exp_w;
		vres_t got;
		if (arst_n && done) begin
			got.r = {r_w, r_z, r_y, r_x};
			got.sc = scalar_out;
			got.flag = flag;
			got.err = error;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word r=%h sc=%h", $time, got.r, got.sc);
				fail_cnt++;
			end else begin
				exp_w = expected_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got.r[i] !== exp_w.r[i]) begin
						$display("%0t: r[%0d] expected %h actual %h", $time, i,
							exp_w.r[i], got.r[i]);
						fail_cnt++;
					end
				if (got.sc !== exp_w.sc) begin
					$display("%0t: scalar_out expected %h actual %h", $time, exp_w.sc, got.sc);
					fail_cnt++;
				end
				if (got.flag !== exp_w.flag) begin
					$display("%0t: flag expected %b actual %b", $time, exp_w.flag, got.flag);
					fail_cnt++;
				end
				if (got.err !== exp_w.err) begin
					$display("%0t: error expected %b actual %b", $time, exp_w.err, got.err);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog: stop when nothing moves for too long
	always @(posedge clk) begin
		int idle_cnt;
		if ((start && !busy) || done || !arst_n)
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 9))
			0: return MAXV;
			1: return MINV;
			2: return 32'(signed'($urandom_range(0, 6)) - 3) <<< FB;
			3, 4: return $urandom();
			default: return 32'(signed'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
		endcase
	endfunction

	function automatic cmd_t make_cmd(logic [3:0] k, logic [3:0][31:0] a,
			logic [3:0][31:0] b, logic [31:0] s);
		cmd_t c;
		c = '0;
		c.ek = ENT_CMD;
		c.kind = k;
		c.a = a;
		c.b = b;
		c.s = s;
		return c;
	endfunction

	function automatic cmd_t make_ctl(ent_kind_t ek, logic [EPS_W-1:0] eps);
		cmd_t c;
		c = '0;
		c.ek = ek;
		c.eps = eps;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c = '0;
		c.ek = ENT_CMD;
		c.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
			: 4'($urandom_range(0, 11));
		for (int i = 0; i < 4; i++) begin
			c.a[i] = rand_val();
			c.b[i] = rand_val();
		end
		c.s = rand_val();
		// Steer toward the interesting corners of each operation
		case ($urandom_range(0, 7))
			0: c.s = 0;
			1: c.a = '0;
			2: for (int i = 0; i < 4; i++)
				c.b[i] = c.a[i] + 32'(signed'($urandom_range(0, 8)) - 4);
			3: c.a[3] = ONE_Q;
			default: ;
		endcase
		return c;
	endfunction

	// Stimulus and end of run
	initial begin
		logic [EPS_W-1:0] eps_plan[5];
		fail_cnt = 0;
		eps_plan = '{17'd0, 17'd65536, 17'd1, 17'd5, 17'd0};
		eps_plan[3] = EPS_W'($urandom_range(2, 65535));

		// Directed words
		pending_q.push_back(make_cmd(OP_ADD, {4{MAXV}}, {4{MAXV}}, 0));
		pending_q.push_back(make_cmd(OP_ADD, {4{MINV}}, {4{MINV}}, 0));
		pending_q.push_back(make_cmd(OP_SUB, {4{MINV}}, {4{MAXV}}, 0));
		pending_q.push_back(make_cmd(OP_NEG, {MINV, MAXV, 32'd0, ONE_Q}, '0, 0));
		pending_q.push_back(make_cmd(OP_SCALE, {4{MAXV}}, '0, MAXV));
		pending_q.push_back(make_cmd(OP_SCALE, {MINV, 32'hFFFF_FFFF, ONE_Q, 32'd3}, '0, MINV));
		pending_q.push_back(make_cmd(OP_DIV, {4{ONE_Q}}, '0, 0));
		pending_q.push_back(make_cmd(OP_DIV, {MINV, MAXV, -ONE_Q, 32'd7}, '0, 32'hFFFF_FFFF));
		pending_q.push_back(make_cmd(OP_DIV, {MINV, MAXV, -ONE_Q, 32'd7}, '0, 32'd3));
		pending_q.push_back(make_cmd(OP_DOT, {4{MINV}}, {4{MINV}}, 0));
		pending_q.push_back(make_cmd(OP_DOT, {4{MAXV}}, {4{MINV}}, 0));
		pending_q.push_back(make_cmd(OP_CROSS, {MAXV, MINV, MAXV, MINV},
			{MINV, MAXV, MINV, MAXV}, 0));
		pending_q.push_back(make_cmd(OP_CROSS, {ONE_Q, 32'd0, ONE_Q, 32'd5},
			{32'd9, ONE_Q, 32'd0, 32'd0}, 0));
		pending_q.push_back(make_cmd(OP_MAG, {4{MINV}}, '0, 0));
		pending_q.push_back(make_cmd(OP_MAG, {32'd0, 32'd4 << FB, 32'd3 << FB, 32'd0}, '0, 0));
		pending_q.push_back(make_cmd(OP_NORM, '0, '0, 0));
		pending_q.push_back(make_cmd(OP_NORM, {32'd0, 32'd0, 32'd0, 32'd1}, '0, 0));
		pending_q.push_back(make_cmd(OP_NORM, {MINV, MAXV, 32'd3, ONE_Q}, '0, 0));
		pending_q.push_back(make_cmd(OP_REFLECT, {MAXV, MINV, ONE_Q, 32'd0},
			{MAXV, MAXV, MINV, ONE_Q}, 0));
		pending_q.push_back(make_cmd(OP_EQUAL, {4{ONE_Q}}, {4{ONE_Q}}, 0));
		pending_q.push_back(make_cmd(OP_EQUAL, {4{MINV}}, {4{MAXV}}, 0));
		pending_q.push_back(make_cmd(OP_ISPOINT, {ONE_Q, 32'd0, 32'd0, 32'd0}, '0, 0));
		pending_q.push_back(make_cmd(OP_ISPOINT, {ONE_Q + 32'd1, 32'd0, 32'd0, 32'd0}, '0, 0));
		pending_q.push_back(make_cmd(4'd12, {4{MAXV}}, {4{MINV}}, MAXV));
		pending_q.push_back(make_cmd(4'd15, {4{MINV}}, {4{MAXV}}, MINV));

		// Random phases, each under the tolerance written at its start
		for (int p = 0; p < 5; p++) begin
			pending_q.push_back(make_ctl(ENT_EPS, eps_plan[p]));
			for (int n = 0; n < 205; n++) begin
				if ($urandom_range(0, 99) == 0)
					pending_q.push_back(make_ctl(ENT_DRAIN, '0));
				pending_q.push_back(rand_cmd());
			end
		end

		wait (arst_n === 1'b1);
		wait (pending_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_cnt == 0 && expected_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
